>>> rtl/gshare_bimodal_branch_predictor_unit_macros.svh
// Assertion macros for the branch predictor unit.
// Clock clk and reset rst are taken from the enclosing module.
`ifndef GSHARE_BIMODAL_BRANCH_PREDICTOR_UNIT_MACROS_SVH
`define GSHARE_BIMODAL_BRANCH_PREDICTOR_UNIT_MACROS_SVH

// Same-cycle implication.
`define GBP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GBP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gbp_pkg.sv
// Shared types and constants for the branch predictor unit.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package gbp_pkg;

  localparam int DefIndexBits = 14;
  localparam int PcW          = 24;
  localparam int CntW         = 3;
  localparam int SmithW       = 8;
  localparam int SmithMaxW    = 8;
  localparam int RegW         = 4;

  localparam logic [CntW-1:0] TableMax = 3'd7;
  localparam logic [CntW-1:0] TableMid = 3'd4;

  localparam logic [1:0] MODE_SMITH   = 2'd0;
  localparam logic [1:0] MODE_BIMODAL = 2'd1;
  localparam logic [1:0] MODE_GSHARE  = 2'd2;

  localparam logic [1:0] REG_MODE    = 2'd0;
  localparam logic [1:0] REG_INDEX   = 2'd1;
  localparam logic [1:0] REG_HISTORY = 2'd2;

  localparam logic [1:0]      ResetMode    = MODE_BIMODAL;
  localparam logic [RegW-1:0] ResetIndex   = 4'd12;
  localparam logic [RegW-1:0] ResetHistory = 4'd8;

  // Effective settings handed from the config block to the datapath.
  typedef struct packed {
    logic [1:0]      mode;
    logic [RegW-1:0] m;        // table index width, clamped
    logic [RegW-1:0] n;        // history length, clamped to m
    logic [RegW-1:0] w;        // smith counter width
    logic            clearing; // table sweep in progress
  } cfg_t;

endpackage

`default_nettype wire

>>> rtl/gbp_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while no read is issued. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module gbp_ram #(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  wire                     clk,
  input  wire                     we,
  input  wire [$clog2(Depth)-1:0] waddr,
  input  wire [Width-1:0]         wdata,
  input  wire                     re,
  input  wire [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]        rdata
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/gbp_cfg.sv
// Configuration registers, clamped settings and the table clearing sweep.
// Depends on gbp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gbp_cfg
  import gbp_pkg::*;
#(
  parameter int INDEX_BITS = DefIndexBits
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_we,
  input  wire [1:0]             cfg_index,
  input  wire [RegW-1:0]        cfg_data,
  output cfg_t                  cfg,
  output logic [INDEX_BITS-1:0] clr_addr
);

  localparam int MaxM = (INDEX_BITS < 15) ? INDEX_BITS : 15;

  logic [1:0]      mode;
  logic [RegW-1:0] index_bits;
  logic [RegW-1:0] history_bits;
  logic            clearing;
  logic [RegW-1:0] m_eff;
  logic [RegW-1:0] n_eff;
  logic            known_reg;

  assign known_reg = (cfg_index == REG_MODE) || (cfg_index == REG_INDEX) ||
                     (cfg_index == REG_HISTORY);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= ResetMode;
      index_bits   <= ResetIndex;
      history_bits <= ResetHistory;
      clearing     <= 1'b1;
      clr_addr     <= '0;
    end else if (cfg_we && known_reg) begin
      case (cfg_index)
        REG_MODE:    mode <= cfg_data[1:0];
        REG_INDEX:   index_bits <= cfg_data;
        REG_HISTORY: history_bits <= cfg_data;
        default:     mode <= mode;
      endcase
      // restart the sweep with the new settings
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (&clr_addr) begin
        clearing <= 1'b0;
      end
    end
  end

  always_comb begin
    if (index_bits == '0) begin
      m_eff = 4'd1;
    end else if (index_bits > RegW'(MaxM)) begin
      m_eff = RegW'(MaxM);
    end else begin
      m_eff = index_bits;
    end
    n_eff = (history_bits > m_eff) ? m_eff : history_bits;
  end

  assign cfg.mode     = mode;
  assign cfg.m        = m_eff;
  assign cfg.n        = n_eff;
  assign cfg.w        = (m_eff > RegW'(SmithMaxW)) ? RegW'(SmithMaxW) : m_eff;
  assign cfg.clearing = clearing;

endmodule

`default_nettype wire

>>> rtl/gshare_bimodal_branch_predictor_unit.sv
// Branch direction predictor: smith counter, bimodal or gshare table of 3-bit counters.
// Uses gbp_pkg, gbp_cfg, gbp_ram and the assertion macro header.
//
// Usage:
//   Input stream s_*: one resolved branch per transfer, s_tdata = {taken, pc}.
//   Output stream m_*: one result per branch, m_tdata = {mispredicted, predicted_taken}.
//   Config port: cfg_we/cfg_index/cfg_data writes mode, index_bits, history_bits.
//   In flight: an accepted branch is held while the counter table RAM read is
//   registered, and its result moves to the output register when the output is
//   free. The read-modify-write of one counter finishes before the next branch
//   is accepted, so only one branch is in flight and the unit cannot take a new
//   branch before it is through with the last one.
//   Reset and every config write to a known register clear the table, history and
//   smith counter: the table is swept through all 2^INDEX_BITS entries to the
//   weakly-taken value at one entry per cycle, while s_tready is low. History
//   clears and the smith counter loads its midpoint during that sweep.
//   When the receiver stalls, the result holds in the output register and the
//   branch in flight waits with its read data held; s_tready stays low until
//   that branch has moved to the output.
`timescale 1ns / 1ps
`default_nettype none

`include "gshare_bimodal_branch_predictor_unit_macros.svh"

module gshare_bimodal_branch_predictor_unit
  import gbp_pkg::*;
#(
  parameter int INDEX_BITS = DefIndexBits
) (
  input  wire             clk,
  input  wire             rst,
  input  wire             s_tvalid,
  output logic            s_tready,
  input  wire [31:0]      s_tdata,   // [23:0] pc, [24] taken, [31:25] zero
  output logic            m_tvalid,
  input  wire             m_tready,
  output logic [7:0]      m_tdata,   // [0] predicted_taken, [1] mispredicted, [7:2] zero
  input  wire             cfg_we,
  input  wire [1:0]       cfg_index,
  input  wire [RegW-1:0]  cfg_data
);

  localparam int HistW = (INDEX_BITS < 15) ? INDEX_BITS : 15;

  cfg_t                  cfg;
  logic [INDEX_BITS-1:0] clr_addr;

  logic [PcW-1:0]        pc;
  logic                  taken;
  logic                  accept;
  logic                  complete;
  logic                  busy;
  logic                  gs;
  logic                  is_smith;

  logic [INDEX_BITS-1:0] pc_bits;
  logic [INDEX_BITS-1:0] mmask;
  logic [HistW-1:0]      nmask;
  logic [INDEX_BITS-1:0] idx;
  logic [HistW-1:0]      hist;
  logic [HistW-1:0]      hist_shr;
  logic [HistW-1:0]      hist_next;

  logic [SmithW-1:0]     smith;
  logic [SmithW-1:0]     smith_mid;
  logic [SmithW-1:0]     smith_hi;
  logic                  smith_pred;

  logic                  taken_q;
  logic                  smith_q;
  logic                  smith_pred_q;
  logic [INDEX_BITS-1:0] idx_q;

  logic [CntW-1:0]       rdata;
  logic [CntW-1:0]       cnt_upd;
  logic                  pred;
  logic                  ram_we;
  logic [INDEX_BITS-1:0] ram_waddr;
  logic [CntW-1:0]       ram_wdata;

  logic                  out_pred;
  logic                  out_mis;

  gbp_cfg #(
    .INDEX_BITS(INDEX_BITS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .clr_addr (clr_addr)
  );

  assign pc       = s_tdata[PcW-1:0];
  assign taken    = s_tdata[PcW];
  assign s_tready = !cfg.clearing && !busy;
  assign accept   = s_tvalid && s_tready;
  assign complete = busy && (!m_tvalid || m_tready);
  assign gs       = cfg.mode[1];
  assign is_smith = (cfg.mode == MODE_SMITH);

  // Table index and next history.
  assign pc_bits  = pc[INDEX_BITS+1:2];
  assign hist_shr = hist >> 1;

  always_comb begin
    for (int i = 0; i < INDEX_BITS; i++) begin
      mmask[i] = (i < int'(cfg.m));
    end
    for (int i = 0; i < HistW; i++) begin
      nmask[i] = (i < int'(cfg.n));
      if (i + 1 < int'(cfg.n)) begin
        hist_next[i] = hist_shr[i];
      end else if (i + 1 == int'(cfg.n)) begin
        hist_next[i] = taken;
      end else begin
        hist_next[i] = 1'b0;
      end
    end
    idx = pc_bits & mmask;
    if (gs) begin
      idx = idx ^ INDEX_BITS'(hist & nmask);
    end
  end

  // Smith counter limits for width w.
  assign smith_mid  = SmithW'(1) << (cfg.w - 4'd1);
  assign smith_hi   = SmithW'((9'd1 << cfg.w) - 9'd1);
  assign smith_pred = (smith >= smith_mid);

  always_ff @(posedge clk) begin
    if (rst || cfg.clearing) begin
      hist  <= '0;
      smith <= smith_mid;
    end else if (accept) begin
      if (is_smith) begin
        if (taken && (smith < smith_hi)) begin
          smith <= smith + 1'b1;
        end else if (!taken && (smith != '0)) begin
          smith <= smith - 1'b1;
        end
      end else if (gs && (cfg.n != '0)) begin
        hist <= hist_next;
      end
    end
  end

  // Item in flight: hold its fields until the result moves to the output.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
    end else if (accept) begin
      busy <= 1'b1;
    end else if (complete) begin
      busy <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      taken_q      <= taken;
      smith_q      <= is_smith;
      smith_pred_q <= smith_pred;
      idx_q        <= idx;
    end
  end

  gbp_ram #(
    .Width(CntW),
    .Depth(1 << INDEX_BITS)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(idx),
    .rdata(rdata)
  );

  always_comb begin
    if (taken_q) begin
      cnt_upd = (rdata == TableMax) ? rdata : rdata + 1'b1;
    end else begin
      cnt_upd = (rdata == '0) ? rdata : rdata - 1'b1;
    end
  end

  assign pred      = smith_q ? smith_pred_q : (rdata >= TableMid);
  assign ram_we    = cfg.clearing || (complete && !smith_q);
  assign ram_waddr = cfg.clearing ? clr_addr : idx_q;
  assign ram_wdata = cfg.clearing ? TableMid : cnt_upd;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (complete) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (complete) begin
      out_pred <= pred;
      out_mis  <= pred ^ taken_q;
    end
  end

  assign m_tdata = {6'b0, out_mis, out_pred};

  `GBP_ASSERT_IMP(a_no_accept_clear, cfg.clearing, !s_tready, "branch accepted during sweep")
  `GBP_ASSERT_NXT(a_accept_busy, accept, busy && !s_tready, "accepted branch not in flight")
  `GBP_ASSERT_NXT(a_stall_hold, busy && m_tvalid && !m_tready, busy && m_tvalid,
                  "in-flight branch lost while output stalled")
  `GBP_ASSERT_IMP(a_write_when, ram_we && !cfg.clearing, complete && !smith_q,
                  "table written outside completion")

endmodule

`default_nettype wire

>>> test/tb.sv
`timescale 1ns / 1ps
// Self-checking bench for gshare_bimodal_branch_predictor_unit: smith, bimodal and gshare modes.
// Depends on gbp_pkg and the unit RTL; predicts every result in a small scoreboard class.

module tb;
  import gbp_pkg::*;

  localparam logic [1:0] MODE_GSHARE_ALIAS = 2'd3;  // unused code, behaves as gshare
  localparam logic [1:0] REG_SPARE         = 2'd3;  // no register behind this index
  localparam int         TableDepth        = 1 << DefIndexBits;
  localparam int         WatchdogLimit     = 100000;
  localparam int         PhaseCount        = 13;
  localparam int         HoldOffCycles     = 300;

  typedef struct packed {
    logic mispredicted;
    logic predicted_taken;
  } verdict_t;

  class direction_scoreboard;
    logic [CntW-1:0] ctr_table [TableDepth];
    int unsigned     ghist;
    int unsigned     smith_ctr;
    logic [1:0]      mode_r;
    logic [RegW-1:0] index_r;
    logic [RegW-1:0] hist_r;
    verdict_t        pending_verdicts [$];
    int unsigned     mismatches;

    function new();
      mode_r     = ResetMode;
      index_r    = ResetIndex;
      hist_r     = ResetHistory;
      mismatches = 0;
      clear_state();
    endfunction

    function int unsigned eff_index();
      int unsigned m;
      m = index_r;
      if (m < 1) m = 1;
      if (m > DefIndexBits) m = DefIndexBits;
      return m;
    endfunction

    function int unsigned eff_hist();
      int unsigned n;
      n = hist_r;
      if (n > eff_index()) n = eff_index();
      return n;
    endfunction

    function int unsigned smith_w();
      return (eff_index() > SmithMaxW) ? SmithMaxW : eff_index();
    endfunction

    function void clear_state();
      foreach (ctr_table[i]) ctr_table[i] = TableMid;
      ghist     = 0;
      smith_ctr = 1 << (smith_w() - 1);
    endfunction

    function void write_reg(logic [1:0] idx, logic [RegW-1:0] val);
      bit known;
      known = 1'b1;
      case (idx)
        REG_MODE:    mode_r  = val[1:0];
        REG_INDEX:   index_r = val;
        REG_HISTORY: hist_r  = val;
        default:     known   = 1'b0;
      endcase
      if (known) clear_state();
    endfunction

    // Predict one branch, then train the selected counter and the history.
    function void log_branch(logic [PcW-1:0] pc, logic tk);
      int unsigned     p;
      int unsigned     w;
      int unsigned     n;
      int unsigned     nmask;
      int unsigned     idx;
      logic            pred;
      logic [CntW-1:0] c;
      verdict_t        v;
      p = pc;
      if (mode_r == MODE_SMITH) begin
        w    = smith_w();
        pred = (smith_ctr >= (1 << (w - 1)));
        if (tk) begin
          if (smith_ctr < (1 << w) - 1) smith_ctr++;
        end else begin
          if (smith_ctr > 0) smith_ctr--;
        end
      end else begin
        n     = eff_hist();
        nmask = (1 << n) - 1;
        idx   = (p >> 2) & ((1 << eff_index()) - 1);
        if (mode_r >= MODE_GSHARE) idx = idx ^ (ghist & nmask);
        idx  = idx & (TableDepth - 1);
        c    = ctr_table[idx];
        pred = (c >= TableMid);
        if (tk) begin
          if (c < TableMax) c++;
        end else begin
          if (c > 0) c--;
        end
        ctr_table[idx] = c;
        if (mode_r >= MODE_GSHARE && n > 0)
          ghist = ((ghist >> 1) | (int'(tk) << (n - 1))) & nmask;
      end
      v.predicted_taken = pred;
      v.mispredicted    = pred ^ tk;
      pending_verdicts.push_back(v);
    endfunction

    function void check_verdict(logic [7:0] data);
      verdict_t v;
      if (pending_verdicts.size() == 0) begin
        $error("result with no branch pending: tdata %h", data);
        mismatches++;
        return;
      end
      v = pending_verdicts.pop_front();
      if (data[0] !== v.predicted_taken) begin
        $error("predicted_taken: expected %0d, got %0d", v.predicted_taken, data[0]);
        mismatches++;
      end
      if (data[1] !== v.mispredicted) begin
        $error("mispredicted: expected %0d, got %0d", v.mispredicted, data[1]);
        mismatches++;
      end
    endfunction

    function int unsigned outstanding();
      return pending_verdicts.size();
    endfunction
  endclass

  logic            clk;
  logic            rst;
  logic            s_tvalid;
  logic            s_tready;
  logic [31:0]     s_tdata;   // [23:0] pc, [24] taken, [31:25] zero
  logic            m_tvalid;
  logic            m_tready;
  logic [7:0]      m_tdata;   // [0] predicted_taken, [1] mispredicted, [7:2] zero
  logic            cfg_we;
  logic [1:0]      cfg_index;
  logic [RegW-1:0] cfg_data;

  direction_scoreboard board = new();
  bit no_idle;
  bit hold_off_req;
  int idle_cycles;

  // Settings per phase; extremes and clamped values included.
  logic [1:0]      ph_mode  [PhaseCount] = '{MODE_SMITH, MODE_SMITH, MODE_SMITH, MODE_BIMODAL,
                                            MODE_BIMODAL, MODE_BIMODAL, MODE_GSHARE, MODE_GSHARE,
                                            MODE_GSHARE, MODE_GSHARE_ALIAS, MODE_GSHARE,
                                            MODE_GSHARE, MODE_GSHARE_ALIAS};
  logic [RegW-1:0] ph_index [PhaseCount] = '{4'd0, 4'd15, 4'd4, 4'd1, 4'd14, 4'd15, 4'd14,
                                            4'd5, 4'd10, 4'd7, 4'd3, 4'd12, 4'd15};
  logic [RegW-1:0] ph_hist  [PhaseCount] = '{4'd0, 4'd3, 4'd0, 4'd0, 4'd14, 4'd9, 4'd14,
                                            4'd15, 4'd0, 4'd5, 4'd2, 4'd8, 4'd15};
  int              ph_items [PhaseCount] = '{60, 350, 80, 80, 150, 100, 150, 120, 100, 120,
                                            120, 150, 100};

  gshare_bimodal_branch_predictor_unit #(
    .INDEX_BITS(DefIndexBits)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_branch(input logic [PcW-1:0] pc, input logic tk);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tdata  <= {7'b0, tk, pc};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    board.log_branch(pc, tk);
  endtask

  // Drop valid and hold until every result is back.
  task automatic drain_results();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [RegW-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    board.write_reg(idx, val);
  endtask

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    m_tready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_req) begin
        @(negedge clk);
        m_tready <= 1'b0;
        repeat (HoldOffCycles) @(negedge clk);
        hold_off_req = 1'b0;
      end
      repeat (pick_gap()) begin
        @(negedge clk);
        m_tready <= 1'b0;
      end
      repeat ($urandom_range(1, 12)) begin
        @(negedge clk);
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) board.check_verdict(m_tdata);
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WatchdogLimit) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    logic [PcW-1:0] pc;
    logic           tk;
    logic           streak;
    logic [PcW-1:0] pool_pc   [8];
    int             pool_bias [8];
    int             flip_den;
    int             k;
    s_tvalid     = 1'b0;
    s_tdata      = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_MODE;
    cfg_data     = '0;
    no_idle      = 1'b0;
    hold_off_req = 1'b0;
    streak       = 1'b1;
    rst          = 1'b1;
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    // Directed, reset settings: saturate one counter both ways, alias on high and low PC bits.
    repeat (4) send_branch(24'h000000, 1'b1);
    repeat (8) send_branch(24'h000000, 1'b0);
    send_branch(24'hFFFFFF, 1'b0);
    send_branch(24'hFFFFFF, 1'b1);
    send_branch(24'h000003, 1'b1);
    send_branch(24'hFFC000, 1'b1);
    send_branch(24'h003FFC, 1'b1);

    for (int p = 0; p < PhaseCount; p++) begin
      drain_results();
      write_reg(REG_MODE, {RegW'($urandom_range(0, 3)) << 2} | RegW'(ph_mode[p]));
      write_reg(REG_INDEX, ph_index[p]);
      write_reg(REG_HISTORY, ph_hist[p]);
      if (p == 5) write_reg(REG_SPARE, RegW'($urandom));
      @(negedge clk);
      cfg_we <= 1'b0;

      for (int j = 0; j < 8; j++) begin
        pool_pc[j]   = PcW'($urandom);
        pool_bias[j] = $urandom_range(0, 1) ? $urandom_range(0, 10) : $urandom_range(90, 100);
      end
      if ($urandom_range(0, 3) == 0) pool_bias[$urandom_range(0, 7)] = 50;
      flip_den = (2 << board.smith_w()) + 2;
      no_idle  = (p == 4 || p == 11);

      for (int i = 0; i < ph_items[p]; i++) begin
        if (i == ph_items[p] / 2) drain_results();
        // start the long hold-off once the sweep is over and branches flow
        if (p == 6 && i == 10) hold_off_req = 1'b1;
        if (ph_mode[p] == MODE_SMITH) begin
          if ($urandom_range(0, flip_den - 1) == 0) streak = ~streak;
          pc = PcW'($urandom);
          tk = streak;
        end else if ($urandom_range(0, 99) < 75) begin
          k  = $urandom_range(0, 7);
          pc = pool_pc[k];
          tk = ($urandom_range(0, 99) < pool_bias[k]);
        end else begin
          pc = PcW'($urandom);
          tk = $urandom_range(0, 1);
        end
        send_branch(pc, tk);
      end
    end

    no_idle = 1'b0;
    drain_results();
    repeat (20) @(posedge clk);
    if (board.mismatches == 0 && board.outstanding() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
